/* rtl/lfpd_pkg.sv */
// Shared types and constants for the line-follow PID drive core.
// Used by lfpd_serial_div, lfpd_serial_mac and line_follow_pid_drive_core.
`timescale 1ns / 1ps

package lfpd_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int SAMPLE_BITS  = 10;
  localparam int IDX_W        = $clog2(SENSOR_COUNT);
  localparam int NORM_W       = 16;            // 0..32768
  localparam int NORM_ONE     = 32768;
  localparam int FRAC_BITS    = 15;            // quotient bits of one normalization
  localparam int POS_W        = 6;             // signed half-unit position 2i-(N-1)
  localparam int NUM_W        = 24;            // signed sum of n*pos
  localparam int DEN_W        = 21;            // sum of n
  localparam int OFF_W        = 16;            // Q3.12 offset, signed
  localparam int OFF_SHIFT    = 11;            // offset = num*2048/den
  localparam int INT_W        = 32;
  localparam int DERIV_W      = OFF_W + 1;

  localparam int IN_DATA_W    = ((SENSOR_COUNT * SAMPLE_BITS + 8 + 7) / 8) * 8;
  localparam int OUT_DATA_W   = 40;

  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 16;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEGRAL = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_THRESH  = 4'd3;

  localparam logic KIND_CAL  = 1'b0;
  localparam logic KIND_CTRL = 1'b1;

  // serial divider
  localparam int DIV_REM_W = 21;
  localparam int DIV_NUM_W = 32;
  localparam int DIV_CNT_W = 6;

  // serial multiply-accumulate
  localparam int GAIN_W  = 16;
  localparam int OPND_W  = 33;
  localparam int ACC_W   = 50;
  localparam int MAC_CNT_W = $clog2(GAIN_W + 1);

  typedef struct packed {
    logic                  start;
    logic [DIV_REM_W-1:0]  rem_init;
    logic [DIV_NUM_W-1:0]  numer;
    logic [DIV_CNT_W-1:0]  steps;
    logic [DIV_REM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIV_NUM_W-1:0]  quot;
  } div_rsp_t;

  typedef struct packed {
    logic                      start;
    logic                      clear;
    logic [GAIN_W-1:0]         gain;
    logic signed [OPND_W-1:0]  opnd;
  } mac_req_t;

  typedef struct packed {
    logic                      busy;
    logic                      done;
    logic signed [ACC_W-1:0]   acc;
  } mac_rsp_t;

endpackage

/* rtl/lfpd_serial_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on lfpd_pkg for request/response structs and widths.
`timescale 1ns / 1ps

module lfpd_serial_div (
  input  logic              clk,
  input  logic              rst,
  input  lfpd_pkg::div_req_t req,
  output lfpd_pkg::div_rsp_t rsp
);
  import lfpd_pkg::*;

  logic [DIV_REM_W-1:0] rem;
  logic [DIV_NUM_W-1:0] numer;
  logic [DIV_NUM_W-1:0] quot;
  logic [DIV_REM_W-1:0] divisor;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [DIV_REM_W:0]   rem_sh;
  logic [DIV_REM_W:0]   rem_diff;
  logic                 fits;

  assign rem_sh   = {rem, numer[DIV_NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign fits     = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.rem_init;
      numer   <= req.numer;
      divisor <= req.divisor;
      cnt     <= req.steps;
      quot    <= '0;
    end else if (busy) begin
      rem   <= fits ? rem_diff[DIV_REM_W-1:0] : rem_sh[DIV_REM_W-1:0];
      numer <= {numer[DIV_NUM_W-2:0], 1'b0};
      quot  <= {quot[DIV_NUM_W-2:0], fits};
      cnt   <= cnt - DIV_CNT_W'(1);
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

/* rtl/lfpd_serial_mac.sv */
// Shift-add multiply-accumulate, one gain bit per cycle.
// Depends on lfpd_pkg for request/response structs and widths.
`timescale 1ns / 1ps

module lfpd_serial_mac (
  input  logic              clk,
  input  logic              rst,
  input  lfpd_pkg::mac_req_t req,
  output lfpd_pkg::mac_rsp_t rsp
);
  import lfpd_pkg::*;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] opnd;
  logic [GAIN_W-1:0]       gain;
  logic [MAC_CNT_W-1:0]    cnt;
  logic                    busy;
  logic                    done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == MAC_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      if (req.clear) begin
        acc <= '0;
      end
      opnd <= ACC_W'(req.opnd);
      gain <= req.gain;
      cnt  <= MAC_CNT_W'(GAIN_W);
    end else if (busy) begin
      if (gain[0]) begin
        acc <= acc + opnd;
      end
      opnd <= opnd <<< 1;
      gain <= gain >> 1;
      cnt  <= cnt - MAC_CNT_W'(1);
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.acc  = acc;

endmodule

/* rtl/line_follow_pid_drive_core.sv */
// Top level of the line-follow PID drive core: sequencer, calibration store,
// PID state and output register. Uses lfpd_pkg, lfpd_serial_div, lfpd_serial_mac.
`timescale 1ns / 1ps
//
// Usage:
//  s_axis: one word per sensor scan. tuser = kind (0 calibrate, 1 control).
//    A calibrate word widens the per-sensor min/max in the accept cycle and
//    gives no result; the core is ready again on the next cycle.
//  A control word is worked through one sensor at a time: each normalization
//  is set directly for a zero or saturated reading, or else uses the shared
//  bit-serial divider (15 quotient bits). The centroid uses the same divider
//  for 32 bits, then three shift-add products with the 16-bit gains form the
//  PID term. The divider and multiplier set how long a control word takes.
//  s_axis_tready is high only while the core is idle.
//  m_axis: one result word per control scan, held in an output register until
//  taken; the core accepts the next scan while it waits. If the register is
//  still full when the next result is ready, the core holds until it drains.
//  cfg: register writes, always ready; write only while no scan is in flight.
//  Reset (rst, synchronous): gains and threshold to defaults, calibration to
//  min 1023 / max 0, PID history cleared, output empty.
module line_follow_pid_drive_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // sensor_0..sensor_7 (10 bits each), base_speed (8)
  input  logic [lfpd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // kind
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // left_dir_pin, left_duty(8), right_dir_pin, right_duty(8), line_offset(15),
  // line_seen, crossing, zero fill
  output logic [lfpd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lfpd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SENS, ST_SDIV, ST_CENT, ST_CDIV, ST_INTEG,
    ST_MP, ST_MI, ST_MD, ST_CMD, ST_OUT
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENSOR_COUNT - 1);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  state_t state;

  logic [CFG_DATA_W-1:0] gain_prop, gain_integral, gain_deriv, cross_threshold;
  logic [SAMPLE_BITS-1:0] cal_low  [SENSOR_COUNT];
  logic [SAMPLE_BITS-1:0] cal_high [SENSOR_COUNT];
  logic [SAMPLE_BITS-1:0] raw_q    [SENSOR_COUNT];
  logic signed [7:0]      speed;

  logic [IDX_W-1:0]        idx;
  logic signed [NUM_W-1:0] num;
  logic [DEN_W-1:0]        den;
  logic [NORM_W-1:0]       n_first, n_last;
  logic                    num_neg;
  logic signed [OFF_W-1:0] off;
  logic                    seen;
  logic signed [OFF_W-1:0] prev_error;
  logic signed [INT_W-1:0] error_integral;
  logic signed [DERIV_W-1:0] dterm;
  logic signed [7:0]       lcmd, rcmd;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mac_req_t mac_req;
  mac_rsp_t mac_rsp;

  lfpd_serial_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));
  lfpd_serial_mac u_mac (.clk(clk), .rst(rst), .req(mac_req), .rsp(mac_rsp));

  function automatic logic signed [POS_W-1:0] sensor_pos(input logic [IDX_W-1:0] i);
    sensor_pos = POS_W'(2 * int'(i) - (SENSOR_COUNT - 1));
  endfunction

  // trunc toward zero of v / 2^20, clamped to -100..100
  function automatic logic signed [7:0] to_cmd(input logic signed [ACC_W+1:0] v);
    logic signed [ACC_W-19:0] q;
    q = (ACC_W - 18)'(v >>> 20);
    if (v < 0 && v[19:0] != '0) begin
      q = q + 1;
    end
    if (q > 100) begin
      to_cmd = 8'sd100;
    end else if (q < -100) begin
      to_cmd = -8'sd100;
    end else begin
      to_cmd = q[7:0];
    end
  endfunction

  // |c| * 255 / 100 via reciprocal 5243 / 2^19, exact for |c| <= 100
  function automatic logic [7:0] duty_of(input logic signed [7:0] c);
    logic [6:0]  a;
    logic [14:0] x;
    logic [27:0] p;
    a = c < 0 ? 7'(-c) : 7'(c);
    x = {a, 8'b0} - 15'(a);
    p = 28'(x) * 28'd5243;
    duty_of = p[26:19];
  endfunction

  // normalization of the current sensor
  logic signed [SAMPLE_BITS:0] dd, rr;
  logic [SAMPLE_BITS:0]        ad, ar;
  logic                        n_zero, n_sat;
  logic [NORM_W-1:0]           n_cur;
  logic                        acc_step;
  logic signed [NORM_W+POS_W:0] prod;

  assign dd = $signed({1'b0, raw_q[idx]}) - $signed({1'b0, cal_low[idx]});
  assign rr = $signed({1'b0, cal_high[idx]}) - $signed({1'b0, cal_low[idx]});
  assign ad = dd[SAMPLE_BITS] ? (SAMPLE_BITS + 1)'(-dd) : dd;
  assign ar = rr[SAMPLE_BITS] ? (SAMPLE_BITS + 1)'(-rr) : rr;
  assign n_zero = rr == '0 || dd == '0 || dd[SAMPLE_BITS] != rr[SAMPLE_BITS];
  assign n_sat  = ad >= ar;

  always_comb begin
    if (state == ST_SDIV) begin
      n_cur = NORM_W'(div_rsp.quot[FRAC_BITS-1:0]);
    end else if (n_zero) begin
      n_cur = '0;
    end else begin
      n_cur = NORM_W'(NORM_ONE);
    end
  end

  assign acc_step = (state == ST_SENS && (n_zero || n_sat)) ||
                    (state == ST_SDIV && div_rsp.done);
  assign prod = $signed({1'b0, n_cur}) * sensor_pos(idx);

  // centroid quotient
  logic [NUM_W-1:0]        anum;
  logic signed [OFF_W-1:0] off_div;
  assign anum = num < 0 ? NUM_W'(-num) : NUM_W'(num);

  always_comb begin
    if (num_neg) begin
      off_div = div_rsp.quot > 32'd16384 ? -16'sd16384 : -$signed(OFF_W'(div_rsp.quot));
    end else begin
      off_div = div_rsp.quot > 32'd16383 ? 16'sd16383 : $signed(OFF_W'(div_rsp.quot));
    end
  end

  // integral update
  logic signed [INT_W:0] integ_sum;
  logic signed [INT_W-1:0] integ_next;
  assign integ_sum = (INT_W + 1)'(error_integral) + (INT_W + 1)'(off);
  always_comb begin
    if (integ_sum > $signed((INT_W + 1)'({1'b0, {(INT_W - 1){1'b1}}}))) begin
      integ_next = {1'b0, {(INT_W - 1){1'b1}}};
    end else if (integ_sum < $signed((INT_W + 1)'({2'b11, {(INT_W - 1){1'b0}}}))) begin
      integ_next = {1'b1, {(INT_W - 1){1'b0}}};
    end else begin
      integ_next = integ_sum[INT_W-1:0];
    end
  end

  // drive commands
  logic signed [ACC_W+1:0] spd_sh, left_v, right_v;
  assign spd_sh  = (ACC_W + 2)'(speed) <<< 20;
  assign left_v  = spd_sh - (ACC_W + 2)'(mac_rsp.acc);
  assign right_v = spd_sh + (ACC_W + 2)'(mac_rsp.acc);

  // unit requests
  always_comb begin
    div_req = '0;
    if (state == ST_SENS && !n_zero && !n_sat) begin
      div_req.start    = 1'b1;
      div_req.rem_init = DIV_REM_W'(ad);
      div_req.steps    = DIV_CNT_W'(FRAC_BITS);
      div_req.divisor  = DIV_REM_W'(ar);
    end else if (state == ST_CENT && den != '0) begin
      div_req.start    = 1'b1;
      div_req.numer    = {anum[DIV_NUM_W-OFF_SHIFT-1:0], {OFF_SHIFT{1'b0}}};
      div_req.steps    = DIV_CNT_W'(DIV_NUM_W);
      div_req.divisor  = DIV_REM_W'(den);
    end
  end

  always_comb begin
    mac_req = '0;
    case (state)
      ST_INTEG: begin
        mac_req.start = 1'b1;
        mac_req.clear = 1'b1;
        mac_req.gain  = gain_prop;
        mac_req.opnd  = OPND_W'(off);
      end
      ST_MP: begin
        mac_req.start = mac_rsp.done;
        mac_req.gain  = gain_integral;
        mac_req.opnd  = OPND_W'(error_integral);
      end
      ST_MI: begin
        mac_req.start = mac_rsp.done;
        mac_req.gain  = gain_deriv;
        mac_req.opnd  = OPND_W'(dterm);
      end
      default: begin
        mac_req = '0;
      end
    endcase
  end

  assign s_axis_tready = state == ST_IDLE;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      m_axis_tvalid   <= 1'b0;
      gain_prop       <= 16'd4608;
      gain_integral   <= 16'd15;
      gain_deriv      <= 16'd6656;
      cross_threshold <= 16'd29491;
      prev_error      <= '0;
      error_integral  <= '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        cal_low[i]  <= SAMPLE_MAX;
        cal_high[i] <= '0;
      end
    end else begin
      // ST_OUT reloads the register itself when it is drained in the same cycle
      if (m_axis_tvalid && m_axis_tready && state != ST_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_GAIN_PROP:     gain_prop       <= cfg_data;
          REG_GAIN_INTEGRAL: gain_integral   <= cfg_data;
          REG_GAIN_DERIV:    gain_deriv      <= cfg_data;
          REG_CROSS_THRESH:  cross_threshold <= cfg_data;
          default: begin
          end
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
              raw_q[i] <= s_axis_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
            end
            speed <= $signed(s_axis_tdata[SENSOR_COUNT*SAMPLE_BITS +: 8]);
            if (s_axis_tuser == KIND_CAL) begin
              for (int i = 0; i < SENSOR_COUNT; i++) begin
                if (s_axis_tdata[i*SAMPLE_BITS +: SAMPLE_BITS] < cal_low[i]) begin
                  cal_low[i] <= s_axis_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
                end
                if (s_axis_tdata[i*SAMPLE_BITS +: SAMPLE_BITS] > cal_high[i]) begin
                  cal_high[i] <= s_axis_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
                end
              end
            end else begin
              idx   <= '0;
              num   <= '0;
              den   <= '0;
              state <= ST_SENS;
            end
          end
        end
        ST_SENS: begin
          if (!acc_step) begin
            state <= ST_SDIV;
          end
        end
        ST_SDIV: begin
          // leaves through the centroid sum update below
        end
        ST_CENT: begin
          num_neg <= num < 0;
          if (den == '0) begin
            off   <= '0;
            seen  <= 1'b0;
            state <= ST_INTEG;
          end else begin
            seen  <= 1'b1;
            state <= ST_CDIV;
          end
        end
        ST_CDIV: begin
          if (div_rsp.done) begin
            off   <= off_div;
            state <= ST_INTEG;
          end
        end
        ST_INTEG: begin
          error_integral <= integ_next;
          dterm          <= DERIV_W'(off) - DERIV_W'(prev_error);
          prev_error     <= off;
          state          <= ST_MP;
        end
        ST_MP: begin
          if (mac_rsp.done) begin
            state <= ST_MI;
          end
        end
        ST_MI: begin
          if (mac_rsp.done) begin
            state <= ST_MD;
          end
        end
        ST_MD: begin
          if (mac_rsp.done) begin
            state <= ST_CMD;
          end
        end
        ST_CMD: begin
          lcmd  <= to_cmd(left_v);
          rcmd  <= to_cmd(right_v);
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {5'b0,
                              (n_first > cross_threshold) || (n_last > cross_threshold),
                              seen, off[14:0],
                              duty_of(rcmd), rcmd > 0,
                              duty_of(lcmd), lcmd < 0};
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // centroid sums, one sensor at a time
      if (acc_step) begin
        num <= num + NUM_W'(prod);
        den <= den + DEN_W'(n_cur);
        if (idx == '0) begin
          n_first <= n_cur;
        end
        if (idx == LAST_IDX) begin
          n_last <= n_cur;
          state  <= ST_CENT;
        end else begin
          idx   <= idx + IDX_W'(1);
          state <= ST_SENS;
        end
      end
    end
  end

  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !div_rsp.busy)
    else $error("divider busy while idle");

  a_idle_mac: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !mac_rsp.busy)
    else $error("multiplier busy while idle");

  a_den_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_CENT |-> den <= DEN_W'(SENSOR_COUNT * NORM_ONE))
    else $error("normalized sum out of range");

  a_off_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_INTEG |-> (off <= 16'sd14336 && off >= -16'sd14336))
    else $error("line offset out of range");

endmodule

/* dv/lfpd_checker.sv */
// Scoreboard for line_follow_pid_drive_core: watches the scan, result and
// register write channels, predicts each result and compares it field by field.
// Depends on lfpd_pkg.
`timescale 1ns / 1ps

module lfpd_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [lfpd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [lfpd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import lfpd_pkg::*;

  typedef struct packed {
    logic        crossing;
    logic        line_seen;
    logic [14:0] line_offset;
    logic [7:0]  right_duty;
    logic        right_dir;
    logic [7:0]  left_duty;
    logic        left_dir;
  } drive_word_t;

  logic [15:0] kp, ki, kd, thresh;
  logic [9:0]  lo_cal [SENSOR_COUNT];
  logic [9:0]  hi_cal [SENSOR_COUNT];
  longint      prev_off, integ;
  drive_word_t drive_q[$];

  assign pending = drive_q.size();

  function automatic longint norm_reading(longint raw, longint lo, longint hi);
    longint d, r, q;
    d = raw - lo;
    r = hi - lo;
    if (r == 0 || d == 0) return 0;
    if ((d < 0) != (r < 0)) return 0;
    if (d < 0) begin
      d = -d;
      r = -r;
    end
    q = d * 32768 / r;
    return (q > 32768) ? 32768 : q;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void motor(longint cmd, bit neg_pin, output logic pin,
                                output logic [7:0] duty);
    longint c, a;
    c = clampl(cmd, -100, 100);
    a = c < 0 ? -c : c;
    pin = neg_pin ? (c < 0) : (c > 0);
    duty = 8'(a * 255 / 100);
  endfunction

  task automatic predict_scan(logic [IN_DATA_W-1:0] d, logic kind);
    longint n[SENSOR_COUNT];
    longint num, den, off, dv, pid, spd;
    drive_word_t w;
    logic [9:0] raw;
    num = 0;
    den = 0;
    off = 0;
    if (kind == KIND_CAL) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        raw = d[i*10 +: 10];
        if (raw < lo_cal[i]) lo_cal[i] = raw;
        if (raw > hi_cal[i]) hi_cal[i] = raw;
      end
      return;
    end
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      n[i] = norm_reading(longint'(d[i*10 +: 10]), longint'(lo_cal[i]),
                          longint'(hi_cal[i]));
      num += n[i] * (2 * i - (SENSOR_COUNT - 1));
      den += n[i];
    end
    if (den != 0) off = clampl(num * 2048 / den, -16384, 16383);
    integ = clampl(integ + off, -64'sd2147483648, 64'sd2147483647);
    dv = off - prev_off;
    prev_off = off;
    pid = longint'(kp) * off + longint'(ki) * integ + longint'(kd) * dv;
    spd = longint'($signed(d[80 +: 8])) * 1048576;
    motor((spd - pid) / 1048576, 1'b1, w.left_dir, w.left_duty);
    motor((spd + pid) / 1048576, 1'b0, w.right_dir, w.right_duty);
    w.line_offset = 15'(off);
    w.line_seen = den != 0;
    w.crossing = (n[0] > thresh) || (n[SENSOR_COUNT-1] > thresh);
    drive_q.push_back(w);
  endtask

  always @(posedge clk) begin
    drive_word_t got, want;
    if (rst) begin
      kp <= 16'd4608;
      ki <= 16'd15;
      kd <= 16'd6656;
      thresh <= 16'd29491;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        lo_cal[i] = 10'd1023;
        hi_cal[i] = 10'd0;
      end
      prev_off = 0;
      integ = 0;
      fail_count <= 0;
      drive_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_PROP:     kp <= cfg_data;
          REG_GAIN_INTEGRAL: ki <= cfg_data;
          REG_GAIN_DERIV:    kd <= cfg_data;
          REG_CROSS_THRESH:  thresh <= cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_scan(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        got = drive_word_t'(m_axis_tdata[34:0]);
        if (drive_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = drive_q.pop_front();
          if (got !== want || m_axis_tdata[39:35] !== 5'd0) begin
            if (fail_count < 10)
              $display("mismatch: exp ldir=%0d lduty=%0d rdir=%0d rduty=%0d off=%h seen=%0d x=%0d / got ldir=%0d lduty=%0d rdir=%0d rduty=%0d off=%h seen=%0d x=%0d",
                       want.left_dir, want.left_duty, want.right_dir, want.right_duty,
                       want.line_offset, want.line_seen, want.crossing,
                       got.left_dir, got.left_duty, got.right_dir, got.right_duty,
                       got.line_offset, got.line_seen, got.crossing);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* dv/line_follow_pid_drive_core_tb.sv */
// Testbench top for line_follow_pid_drive_core: clock, reset, scan and
// register stimulus, result stalls and the verdict. Uses lfpd_pkg, lfpd_checker.
`timescale 1ns / 1ps

module line_follow_pid_drive_core_tb;
  import lfpd_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int fail_count, pending;
  bit hold_off = 1'b0;

  always #1 clk = ~clk;

  line_follow_pid_drive_core u_dut (.*);
  lfpd_checker u_chk (.*);

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int idle_n;
    @(negedge clk);
    forever begin
      idle_n = $urandom_range(0, 4);
      if (idle_n != 0 || hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (idle_n) @(negedge clk);
        while (hold_off) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // leaves tvalid high at the final negedge; the next step drops or reuses it
  task automatic send_scan(logic kind, logic [9:0] s[8], logic [7:0] spd, bit gaps);
    int idle_n;
    idle_n = gaps ? $urandom_range(0, 4) : 0;
    if (idle_n != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle_n) @(negedge clk);
    end
    for (int i = 0; i < 8; i++) s_axis_tdata[i*10 +: 10] <= s[i];
    s_axis_tdata[80 +: 8] <= spd;
    s_axis_tuser <= kind;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic rand_scan(logic kind, int style, bit gaps);
    logic [9:0] s[8];
    for (int i = 0; i < 8; i++)
      case (style)
        0: s[i] = 10'($urandom);
        1: s[i] = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(700, 1023))
                                             : 10'($urandom_range(0, 200));
        default: s[i] = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
      endcase
    send_scan(kind, s, 8'($urandom), gaps);
  endtask

  initial begin
    logic [9:0] s[8];
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    // uncalibrated control scan of equal readings gives zero offset, line seen
    s = '{default: 10'd500};
    send_scan(KIND_CTRL, s, 8'd50, 1'b1);
    // calibrate full range on every sensor
    s = '{default: 10'd0};
    send_scan(KIND_CAL, s, 8'd0, 1'b1);
    s = '{default: 10'd1023};
    send_scan(KIND_CAL, s, 8'd0, 1'b1);
    for (int k = 0; k < 8; k++) begin
      s = '{default: 10'd0};
      s[k] = 10'd1023;
      send_scan(KIND_CTRL, s, k[0] ? 8'h80 : 8'h7f, 1'b1);
    end
    s = '{default: 10'd0};
    send_scan(KIND_CTRL, s, 8'd0, 1'b1);
    s = '{default: 10'd1023};
    send_scan(KIND_CTRL, s, 8'hff, 1'b1);
    // max gains, line held at the last sensor, crossing threshold zero
    write_reg(REG_GAIN_PROP, 16'hffff);
    write_reg(REG_GAIN_INTEGRAL, 16'hffff);
    write_reg(REG_GAIN_DERIV, 16'hffff);
    write_reg(REG_CROSS_THRESH, 16'd0);
    s = '{default: 10'd0};
    s[7] = 10'd1023;
    repeat (6) send_scan(KIND_CTRL, s, 8'd10, 1'b0);
    write_reg(REG_CROSS_THRESH, 16'd32768);
    write_reg(REG_GAIN_INTEGRAL, 16'd0);
    write_reg(4'd9, 16'h1234);
    s = '{default: 10'd1023};
    send_scan(KIND_CTRL, s, 8'd0, 1'b0);
    // long hold-off: block fills up and stalls its input
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
      end
      repeat (5) rand_scan(KIND_CTRL, 1, 1'b0);
    join
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_GAIN_PROP, 16'd4608);
          write_reg(REG_GAIN_INTEGRAL, 16'd15);
          write_reg(REG_GAIN_DERIV, 16'd6656);
          write_reg(REG_CROSS_THRESH, 16'd29491);
        end
        1: begin
          write_reg(REG_GAIN_PROP, 16'($urandom));
          write_reg(REG_GAIN_INTEGRAL, 16'($urandom_range(0, 300)));
          write_reg(REG_CROSS_THRESH, 16'($urandom_range(0, 32768)));
        end
        2: begin
          write_reg(REG_GAIN_PROP, 16'd0);
          write_reg(REG_GAIN_DERIV, 16'd0);
          write_reg(REG_GAIN_INTEGRAL, 16'd0);
        end
        default: begin
          write_reg(REG_GAIN_PROP, 16'd256);
          write_reg(REG_GAIN_DERIV, 16'($urandom));
          write_reg(REG_CROSS_THRESH, 16'd16384);
        end
      endcase
      for (int n = 0; n < 270; n++) begin
        int r;
        r = $urandom_range(0, 9);
        // stretches without gaps in the middle of each phase
        rand_scan((r < 2) ? KIND_CAL : KIND_CTRL, (r < 6) ? 1 : (r < 8 ? 0 : 2),
                  !(n >= 100 && n < 130));
      end
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0) $display("line_follow_pid_drive_core test passed");
    else $display("line_follow_pid_drive_core test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("line_follow_pid_drive_core test failed");
    $finish;
  end
endmodule
